### rtl/sge_pkg.sv
// ----------------------------------------------------------------------------
// sge_pkg
// Shared types, constants and helpers of the RGB to gray Sobel edge block.
// ----------------------------------------------------------------------------
package sge_pkg;

  // Field widths
  localparam int unsigned PIX_W = 8;
  localparam int unsigned ROW_W = 11;
  localparam int unsigned CFG_W = 12;
  localparam int unsigned MAX_HEIGHT = 2048;

  // BT.709 weights in 8-bit fixed point
  localparam int unsigned GRAY_R_W = 54;
  localparam int unsigned GRAY_G_W = 183;
  localparam int unsigned GRAY_B_W = 18;

  // Result queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

  // Configuration register indexes
  localparam logic [1:0] CFG_FRAME_WIDTH = 2'd0;
  localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;

  // One queue entry: the result of one pixel, plus an optional right border beat
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] col;
    logic [ROW_W-1:0] second_col;
    logic [PIX_W-1:0] mag;
    logic             dual;
    logic             done;
  } sge_entry_t;

  // Output beat sequencer state
  typedef enum logic {
    BEAT_FIRST,
    BEAT_SECOND
  } beat_e;

  // Clamp a size register to [3, hi] and return the last index
  function automatic int unsigned last_index(logic [CFG_W-1:0] value, int unsigned hi);
    int unsigned v;
    v = 32'(value);
    if (v < 3) v = 3;
    if (v > hi) v = hi;
    return v - 1;
  endfunction

endpackage

### rtl/sge_ram.sv
// ----------------------------------------------------------------------------
// sge_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sge_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/sge_fifo.sv
// ----------------------------------------------------------------------------
// sge_fifo
// Short show-ahead queue of result entries between the front and the back.
// ----------------------------------------------------------------------------
module sge_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  sge_pkg::sge_entry_t entry_i,
  input  logic                pop_i,
  output logic                valid_o,
  output sge_pkg::sge_entry_t entry_o
);
  import sge_pkg::*;

  sge_entry_t        mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q + QPTR_W'(push_i);
    rd_ptr_d = rd_ptr_q + QPTR_W'(pop_i);
    count_d  = count_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

endmodule

### rtl/sge_front.sv
// ----------------------------------------------------------------------------
// sge_front
// Pixel intake: gray conversion, raster counters, line buffers, 3x3 window
// and Sobel magnitude; pushes one queue entry per pixel that has results.
// ----------------------------------------------------------------------------
module sge_front #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [sge_pkg::PIX_W-1:0]       red_i,
  input  logic [sge_pkg::PIX_W-1:0]       green_i,
  input  logic [sge_pkg::PIX_W-1:0]       blue_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]    wlast_i,
  input  logic [sge_pkg::ROW_W-1:0]       hlast_i,
  input  logic                            retire_i,
  output logic                            push_o,
  output sge_pkg::sge_entry_t             entry_o
);
  import sge_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);

  // L1 Sobel magnitude of a window, saturated to 8 bits
  function automatic logic [PIX_W-1:0] sobel_mag(logic [PIX_W-1:0] w [9]);
    logic signed [11:0] gx;
    logic signed [11:0] gy;
    logic [11:0]        ax;
    logic [11:0]        ay;
    logic [11:0]        s;
    gx = $signed({4'd0, w[2]}) + $signed({3'd0, w[5], 1'b0}) + $signed({4'd0, w[8]})
       - $signed({4'd0, w[0]}) - $signed({3'd0, w[3], 1'b0}) - $signed({4'd0, w[6]});
    gy = $signed({4'd0, w[6]}) + $signed({3'd0, w[7], 1'b0}) + $signed({4'd0, w[8]})
       - $signed({4'd0, w[0]}) - $signed({3'd0, w[1], 1'b0}) - $signed({4'd0, w[2]});
    ax = gx[11] ? 12'(-gx) : 12'(gx);
    ay = gy[11] ? 12'(-gy) : 12'(gy);
    s  = ax + ay;
    return (s > 12'd255) ? 8'hFF : s[7:0];
  endfunction

  logic              accept;
  logic [15:0]       gray_sum;
  logic [CW-1:0]     col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic              last_col;
  logic              last_row;
  logic [QCNT_W-1:0] credit_q, credit_d;

  // Stage 1 registers
  logic              s1_valid_q;
  logic [PIX_W-1:0]  s1_gray_q;
  logic [CW-1:0]     s1_col_q;
  logic [ROW_W-1:0]  s1_row_q;
  logic              s1_last_col_q;
  logic              s1_last_row_q;

  // Stage 2 registers
  logic              s2_valid_q;
  logic              s2_has_q;
  logic              s2_interior_q;
  logic [ROW_W-1:0]  s2_row_q;
  logic [ROW_W-1:0]  s2_col_q;
  logic [ROW_W-1:0]  s2_second_col_q;
  logic              s2_dual_q;
  logic              s2_done_q;

  logic [PIX_W-1:0]  win_q [9];
  logic [PIX_W-1:0]  prev_rd;
  logic [PIX_W-1:0]  prev2_rd;
  logic [CW-1:0]     s1_ccol;
  logic [ROW_W-1:0]  s1_crow;
  logic              s2_drop;

  // Hold the input while every queue slot is spoken for
  assign in_stall_o = (credit_q == QCNT_W'(QDEPTH));
  assign accept     = in_valid_i && !in_stall_o;

  // Gray conversion
  assign gray_sum = 16'(GRAY_R_W * 32'(red_i) + GRAY_G_W * 32'(green_i)
                        + GRAY_B_W * 32'(blue_i));

  // Raster counters
  always_comb begin
    last_col = (col_q >= wlast_i);
    last_row = (row_q >= hlast_i);
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  // Track items in flight or queued
  assign s2_drop  = s2_valid_q && !s2_has_q;
  assign credit_d = credit_q + QCNT_W'(accept) - QCNT_W'(s2_drop) - QCNT_W'(retire_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      credit_q   <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      credit_q   <= credit_d;
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
    end
  end

  // Stage 1 capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_gray_q     <= gray_sum[15:8];
      s1_col_q      <= col_q;
      s1_row_q      <= row_q;
      s1_last_col_q <= last_col;
      s1_last_row_q <= last_row;
    end
  end

  // Line buffers: row r-1 and row r-2
  sge_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_prev (
    .clk_i     (clk_i),
    .wr_en_i   (s1_valid_q),
    .wr_addr_i (s1_col_q),
    .wr_data_i (s1_gray_q),
    .rd_en_i   (accept),
    .rd_addr_i (col_q),
    .rd_data_o (prev_rd)
  );

  sge_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_prev2 (
    .clk_i     (clk_i),
    .wr_en_i   (s1_valid_q),
    .wr_addr_i (s1_col_q),
    .wr_data_i (prev_rd),
    .rd_en_i   (accept),
    .rd_addr_i (col_q),
    .rd_data_o (prev2_rd)
  );

  // Shift the window one column
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_valid_q) begin
      for (int k = 0; k < 3; k++) begin
        win_q[k*3]   <= win_q[k*3+1];
        win_q[k*3+1] <= win_q[k*3+2];
      end
      win_q[2] <= prev2_rd;
      win_q[5] <= prev_rd;
      win_q[8] <= s1_gray_q;
    end
  end

  // Classify the result of stage 1
  assign s1_ccol = s1_col_q - 1'b1;
  assign s1_crow = s1_row_q - 1'b1;

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_has_q        <= (s1_row_q != '0) && (s1_col_q != '0);
      s2_interior_q   <= (s1_crow != '0) && (s1_ccol != '0) && (s1_ccol < wlast_i);
      s2_row_q        <= s1_crow;
      s2_col_q        <= ROW_W'(s1_ccol);
      s2_second_col_q <= ROW_W'(wlast_i);
      s2_dual_q       <= s1_last_col_q;
      s2_done_q       <= s1_last_row_q;
    end
  end

  // Push the entry with its magnitude
  assign push_o = s2_valid_q && s2_has_q;

  always_comb begin
    entry_o.row        = s2_row_q;
    entry_o.col        = s2_col_q;
    entry_o.second_col = s2_second_col_q;
    entry_o.mag        = s2_interior_q ? sobel_mag(win_q) : '0;
    entry_o.dual       = s2_dual_q;
    entry_o.done       = s2_done_q;
  end

endmodule

### rtl/sge_back.sv
// ----------------------------------------------------------------------------
// sge_back
// Result sender: emits each queue entry as one beat, or two beats when the
// pixel closes a row and the right border result follows.
// ----------------------------------------------------------------------------
module sge_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      head_valid_i,
  input  sge_pkg::sge_entry_t       head_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [sge_pkg::ROW_W-1:0] out_row_o,
  output logic [sge_pkg::ROW_W-1:0] out_col_o,
  output logic [sge_pkg::PIX_W-1:0] magnitude_o,
  output logic                      frame_done_o
);
  import sge_pkg::*;

  beat_e state_q, state_d;
  logic  beat_taken;

  assign out_valid_o = head_valid_i;
  assign beat_taken  = head_valid_i && !out_stall_i;
  assign out_row_o   = head_i.row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BEAT_FIRST;
    end else begin
      state_q <= state_d;
    end
  end

  // Select the beat and advance
  always_comb begin
    state_d      = state_q;
    pop_o        = 1'b0;
    out_col_o    = head_i.col;
    magnitude_o  = head_i.mag;
    frame_done_o = 1'b0;
    case (state_q)
      BEAT_FIRST: begin
        if (beat_taken) begin
          if (head_i.dual) begin
            state_d = BEAT_SECOND;
          end else begin
            pop_o = 1'b1;
          end
        end
      end
      BEAT_SECOND: begin
        out_col_o    = head_i.second_col;
        magnitude_o  = '0;
        frame_done_o = head_i.done;
        if (beat_taken) begin
          pop_o   = 1'b1;
          state_d = BEAT_FIRST;
        end
      end
      default: begin
        state_d = BEAT_FIRST;
      end
    endcase
  end

endmodule

### rtl/rgb_gray_sobel_edge_top.sv
// ----------------------------------------------------------------------------
// rgb_gray_sobel_edge_top
// RGB pixel stream in, Sobel L1 edge magnitude per pixel out.
//
// Input channel: one RGB pixel per beat in raster order; the block converts
// it to gray, keeps two line buffers and a 3x3 window, and emits results one
// row and one column behind. Output channel: one result per beat with its
// row, column, saturated magnitude and a frame_done flag on the frame's last
// result. Border results carry magnitude zero; the bottom row is not sent.
// Configuration: write frame_width (index 0) and frame_height (index 1) over
// the cfg channel while no pixel is in flight; it is always ready.
// Path: a pixel is registered in stage 1, then stage 2, then any result
// it has enters the queue. Throughput: one pixel per cycle when not stalled;
// the last pixel of a row carries two results, sent as two output beats.
// Flow: a four-entry result queue parts intake from output; the input stalls
// once four pixels are in flight or queued, and drains as the receiver takes
// beats. A receiver stall holds the current beat unchanged.
// Reset: counters at zero, width 640, height 480; line buffers need no clear.
// ----------------------------------------------------------------------------
module rgb_gray_sobel_edge_top #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [sge_pkg::PIX_W-1:0] red_i,
  input  logic [sge_pkg::PIX_W-1:0] green_i,
  input  logic [sge_pkg::PIX_W-1:0] blue_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [sge_pkg::ROW_W-1:0] out_row_o,
  output logic [sge_pkg::ROW_W-1:0] out_col_o,
  output logic [sge_pkg::PIX_W-1:0] magnitude_o,
  output logic                      frame_done_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [1:0]                cfg_index_i,
  input  logic [sge_pkg::CFG_W-1:0] cfg_data_i
);
  import sge_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);

  logic [CW-1:0]    wlast_q, wlast_d;
  logic [ROW_W-1:0] hlast_q, hlast_d;
  logic             push;
  logic             pop;
  logic             head_valid;
  sge_entry_t       push_entry;
  sge_entry_t       head_entry;

  assign cfg_ready_o = 1'b1;

  // Decode configuration writes into clamped last indexes
  always_comb begin
    wlast_d = wlast_q;
    hlast_d = hlast_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_FRAME_WIDTH:  wlast_d = CW'(last_index(cfg_data_i, MAX_WIDTH));
        CFG_FRAME_HEIGHT: hlast_d = ROW_W'(last_index(cfg_data_i, MAX_HEIGHT));
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlast_q <= CW'(last_index(12'd640, MAX_WIDTH));
      hlast_q <= ROW_W'(last_index(12'd480, MAX_HEIGHT));
    end else begin
      wlast_q <= wlast_d;
      hlast_q <= hlast_d;
    end
  end

  sge_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .red_i      (red_i),
    .green_i    (green_i),
    .blue_i     (blue_i),
    .wlast_i    (wlast_q),
    .hlast_i    (hlast_q),
    .retire_i   (pop),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  sge_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .valid_o (head_valid),
    .entry_o (head_entry)
  );

  sge_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_entry),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .magnitude_o  (magnitude_o),
    .frame_done_o (frame_done_o)
  );

endmodule
